// File: design/gvss_pkg.sv
// Package for the GPIO voltage step selector: sizes, codes, item types and sequencer states.
package gvss_pkg;

	// Table and line sizes.
	localparam int unsigned MAX_ENTRIES = 5;
	localparam int unsigned MAX_LINES   = 16;
	localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
	localparam int unsigned LC_W        = $clog2(MAX_LINES + 1);
	localparam int unsigned MV_W        = 16;
	localparam int unsigned SEL_W       = 16;
	localparam int unsigned CFG_W       = 32;
	localparam int unsigned CFG_IDX_W   = 3;

	// Action codes.
	localparam logic [1:0] ACT_QUERY   = 2'd0;
	localparam logic [1:0] ACT_SET     = 2'd1;
	localparam logic [1:0] ACT_STARTUP = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_INDEX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_0       = 3'd3;

	// Request item.
	typedef struct packed {
		logic [1:0]      action;
		logic [MV_W-1:0] min_mv;
		logic [MV_W-1:0] max_mv;
	} req_t;

	// Result item.
	typedef struct packed {
		logic             status;
		logic [2:0]       chosen_index;
		logic [MV_W-1:0]  current_mv;
		logic [15:0]      line_drive;
	} rsp_t;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_COUNT = 6'b000010,
		S_LOAD  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

endpackage

// File: design/gpio_voltage_step_select.sv
// GPIO voltage step selector: table scan sequencer, current step register and line drive.
// Steps: an accepted item runs the count pass, which stops early at the first entry that does not
// rise, then the load, the scan over the usable entries, the check and the done state and strobe.
// A rejected startup item skips the scan and the check.
// Items: the next item is taken at the edge that ends the strobe cycle; no new item is taken
// while busy, and the receiver cannot stall results.
// Reset: asynchronous, active low; the control registers go to their reset values, current step is 0.
module gpio_voltage_step_select
	import gvss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration and control state.
	state_t               state_q;
	logic [2:0]           entry_count_q;
	logic [LC_W-1:0]      line_count_q;
	logic [2:0]           startup_q;
	logic [CFG_W-1:0]     entry_q [MAX_ENTRIES];
	logic [IDX_W-1:0]     cur_q;
	logic [IDX_W-1:0]     idx_q;
	logic [2:0]           n_q;
	logic                 done_q;

	// Item payload registers.
	logic [1:0]           act_q;
	logic [MV_W-1:0]      lo_q;
	logic [MV_W-1:0]      hi_q;
	logic [MV_W-1:0]      prev_mv_q;
	logic [MV_W-1:0]      start_mv_q;
	logic [MV_W:0]        sum_q;
	logic [IDX_W-1:0]     best_q;
	logic [MV_W:0]        best_d_q;
	logic [MV_W-1:0]      best_mv_q;
	logic                 status_q;
	rsp_t                 rsp_q;

	// Combinational signals.
	logic [IDX_W-1:0]     rd_idx;
	logic [CFG_W-1:0]     rd_entry;
	logic [MV_W-1:0]      rd_mv;
	logic [SEL_W-1:0]     rd_sel;
	logic [2:0]           lim;
	logic                 count_stop;
	logic                 count_last;
	logic                 start_ok;
	logic [MV_W-1:0]      lo_sel;
	logic [MV_W-1:0]      hi_sel;
	logic [MV_W+1:0]      diff;
	logic [MV_W:0]        mv_gap;
	logic                 better;
	logic                 scan_last;
	logic                 check_ok;
	logic [LC_W-1:0]      lc_sat;
	logic [15:0]          drive;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Single table read port; the sequencer chooses the entry.
	always_comb begin
		unique case (state_q)
			S_DONE:  rd_idx = cur_q;
			default: rd_idx = idx_q;
		endcase
		rd_entry = (32'(rd_idx) < MAX_ENTRIES) ? entry_q[rd_idx] : '0;
		rd_mv    = rd_entry[MV_W-1:0];
		rd_sel   = rd_entry[CFG_W-1:MV_W];
	end

	// Usable count pass: stop at the limit or the first entry that does not rise.
	always_comb begin
		if (entry_count_q == 3'd0) begin
			lim = 3'd1;
		end else if (32'(entry_count_q) > MAX_ENTRIES) begin
			lim = 3'(MAX_ENTRIES);
		end else begin
			lim = entry_count_q;
		end
		count_stop = (idx_q != '0) && ((3'(idx_q) >= lim) || (rd_mv <= prev_mv_q));
		count_last = (32'(idx_q) == MAX_ENTRIES - 1);
		start_ok   = (startup_q < n_q);
	end

	// Bounds for the scan: the startup action uses the startup entry for both.
	always_comb begin
		if (act_q == ACT_STARTUP) begin
			lo_sel = start_mv_q;
			hi_sel = start_mv_q;
		end else begin
			lo_sel = lo_q;
			hi_sel = hi_q;
		end
	end

	// Distance unit for the scan: |2v - (min + max)|, ties keep the lower index.
	always_comb begin
		diff      = {1'b0, rd_mv, 1'b0} - {1'b0, sum_q};
		mv_gap    = diff[MV_W+1] ? (MV_W+1)'(-diff) : diff[MV_W:0];
		better    = (idx_q == '0) || (mv_gap < best_d_q);
		scan_last = (3'(idx_q) == 3'(n_q - 3'd1));
		check_ok  = (best_mv_q >= lo_q) && (best_mv_q <= hi_q);
	end

	// Line drive: line i takes select bit (line count - 1 - i).
	always_comb begin
		logic [LC_W-1:0] b;
		lc_sat = (32'(line_count_q) > MAX_LINES) ? LC_W'(MAX_LINES) : line_count_q;
		drive  = '0;
		for (int i = 0; i < MAX_LINES; i++) begin
			b = LC_W'(lc_sat - LC_W'(1) - LC_W'(i));
			if (LC_W'(i) < lc_sat) begin
				drive[i] = rd_sel[b[$clog2(SEL_W)-1:0]];
			end
		end
	end

	// Control registers and configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= 3'd1;
			line_count_q  <= LC_W'(1);
			startup_q     <= 3'd0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				entry_q[i] <= '0;
			end
			cur_q         <= '0;
			idx_q         <= '0;
			n_q           <= 3'd1;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENTRY_COUNT:   entry_count_q <= cfg_data[2:0];
					REG_LINE_COUNT:    line_count_q  <= cfg_data[LC_W-1:0];
					REG_STARTUP_INDEX: startup_q     <= cfg_data[2:0];
					default:           entry_q[IDX_W'(cfg_index - REG_ENTRY_0)] <= cfg_data;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					if (count_stop) begin
						n_q     <= 3'(idx_q);
						state_q <= S_LOAD;
					end else if (count_last) begin
						n_q     <= 3'(MAX_ENTRIES);
						state_q <= S_LOAD;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_LOAD: begin
					idx_q <= '0;
					if ((act_q == ACT_STARTUP) && !start_ok) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_CHECK;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_CHECK: begin
					if (check_ok && ((act_q == ACT_SET) || (act_q == ACT_STARTUP))) begin
						cur_q <= best_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload path.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					act_q <= req.action;
					lo_q  <= req.min_mv;
					hi_q  <= req.max_mv;
				end
			end
			S_COUNT: begin
				if (!count_stop) begin
					prev_mv_q <= rd_mv;
					if (3'(idx_q) == startup_q) begin
						start_mv_q <= rd_mv;
					end
				end
			end
			S_LOAD: begin
				lo_q     <= lo_sel;
				hi_q     <= hi_sel;
				sum_q    <= {1'b0, lo_sel} + {1'b0, hi_sel};
				best_q   <= '0;
				status_q <= 1'b1;
			end
			S_SCAN: begin
				if (better) begin
					best_q    <= idx_q;
					best_d_q  <= mv_gap;
					best_mv_q <= rd_mv;
				end
			end
			S_CHECK: begin
				status_q <= !check_ok;
			end
			S_DONE: begin
				rsp_q.status       <= status_q;
				rsp_q.chosen_index <= 3'(best_q);
				rsp_q.current_mv   <= rd_mv;
				rsp_q.line_drive   <= drive;
			end
			default: ;
		endcase
	end

	// A result strobe only follows the final sequencer step.
	a_done_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_DONE))
		else $error("result strobe without a finished item");

	// An accepted item makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start the sequencer");

	// The scan never runs beyond the usable entries.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (3'(idx_q) < n_q))
		else $error("scan index beyond usable count");

	// The current step always names a table entry.
	a_cur_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < MAX_ENTRIES)
		else $error("current step outside the table");

	// A reported index always lies in the table.
	a_chosen_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(rsp.chosen_index) < MAX_ENTRIES))
		else $error("chosen index outside the table");

endmodule
